// ===== design/sipft_pkg.sv =====
// Shared types, constants and command/status bundles for the source IP filter table.
// Used by the controller, the datapath and the top level; no dependencies.
`default_nettype none

package sipft_pkg;

  // Table geometry
  localparam int MAX_RULES = 64;
  localparam int IDX_W     = $clog2(MAX_RULES);
  localparam int CNT_W     = $clog2(MAX_RULES + 1);

  // Field widths
  localparam int REQ_W  = 3;
  localparam int IP_W   = 32;
  localparam int ACT_W  = 8;
  localparam int HITS_W = 64;
  localparam int STS_W  = 3;

  // Stream payload widths (byte aligned)
  localparam int IN_FIELDS_W  = IP_W + ACT_W + IDX_W;
  localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = STS_W + 1 + 1 + IDX_W + CNT_W + IP_W + 1 + HITS_W;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  typedef enum logic [REQ_W-1:0] {
    REQ_LOOKUP = 3'd0,
    REQ_ADD    = 3'd1,
    REQ_DELETE = 3'd2,
    REQ_CLEAR  = 3'd3,
    REQ_READ   = 3'd4
  } req_e;

  typedef enum logic [STS_W-1:0] {
    STS_OK         = 3'd0,
    STS_BAD_ACTION = 3'd1,
    STS_FULL       = 3'd2,
    STS_NOT_FOUND  = 3'd3,
    STS_RANGE      = 3'd4
  } sts_code_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_SCAN,
    ST_HIT,
    ST_MISS,
    ST_READ,
    ST_SH_RD,
    ST_SH_WR,
    ST_DONE
  } state_e;

  typedef enum logic [1:0] {
    RD_SCAN,
    RD_INDEX,
    RD_SHIFT
  } rd_sel_e;

  typedef enum logic [2:0] {
    WR_NONE,
    WR_BUMP,
    WR_ACTION,
    WR_APPEND,
    WR_SHIFT
  } wr_sel_e;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_CLEAR,
    CNT_INC,
    CNT_DEC
  } cnt_op_e;

  // One table entry as stored in the RAM
  typedef struct packed {
    logic [IP_W-1:0]   addr;
    logic              drop;
    logic [HITS_W-1:0] hits;
  } entry_t;

  // Result fields built up while a request is worked on
  typedef struct packed {
    sts_code_e         status;
    logic              verdict;
    logic              matched;
    logic [IDX_W-1:0]  match_index;
    logic [IP_W-1:0]   entry_src_ip;
    logic              entry_action;
    logic [HITS_W-1:0] entry_hits;
  } res_t;

  // Controller to datapath
  typedef struct packed {
    logic      accept;
    logic      scan;
    logic      capture;
    logic      rd_en;
    rd_sel_e   rd_sel;
    wr_sel_e   wr_sel;
    cnt_op_e   cnt_op;
    logic      set_status;
    sts_code_e status;
    logic      res_hit;
    logic      res_entry;
    logic      sh_init;
    logic      sh_inc;
    logic      push;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [REQ_W-1:0] req;
    logic             act_bad;
    logic             idx_bad;
    logic             full;
    logic             hit;
    logic             miss;
    logic             sh_more;
    logic             out_busy;
  } sts_t;

endpackage

`default_nettype wire

// ===== design/sipft_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No package dependency; holds the rule table entries.
`default_nettype none

module sipft_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== design/sipft_ctrl.sv =====
// Request sequencer for the source IP filter table.
// Depends on sipft_pkg; drives the datapath through cmd_t and reads sts_t.
`default_nettype none

module sipft_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            req_valid_i,
  output      logic            req_ready_o,
  input  wire sipft_pkg::sts_t sts_i,
  output      sipft_pkg::cmd_t cmd_o
);

  import sipft_pkg::*;

  state_e state_q, state_d;

  assign req_ready_o = (state_q == ST_IDLE);

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (req_valid_i) begin
          state_d = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        case (sts_i.req)
          REQ_LOOKUP, REQ_DELETE: state_d = ST_SCAN;
          REQ_ADD:                state_d = sts_i.act_bad ? ST_DONE : ST_SCAN;
          REQ_READ:               state_d = sts_i.idx_bad ? ST_DONE : ST_READ;
          default:                state_d = ST_DONE;
        endcase
      end
      ST_SCAN: begin
        if (sts_i.hit) begin
          state_d = ST_HIT;
        end else if (sts_i.miss) begin
          state_d = ST_MISS;
        end
      end
      ST_HIT: begin
        state_d = (sts_i.req == REQ_DELETE) ? ST_SH_RD : ST_DONE;
      end
      ST_MISS:  state_d = ST_DONE;
      ST_READ:  state_d = ST_DONE;
      ST_SH_RD: state_d = sts_i.sh_more ? ST_SH_WR : ST_DONE;
      ST_SH_WR: state_d = ST_SH_RD;
      ST_DONE: begin
        if (!sts_i.out_busy) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Command outputs
  always_comb begin
    cmd_o            = '0;
    cmd_o.rd_sel     = RD_SCAN;
    cmd_o.wr_sel     = WR_NONE;
    cmd_o.cnt_op     = CNT_HOLD;
    cmd_o.status     = STS_OK;
    case (state_q)
      ST_IDLE: begin
        cmd_o.accept = req_valid_i;
      end
      ST_DISPATCH: begin
        case (sts_i.req)
          REQ_ADD: begin
            if (sts_i.act_bad) begin
              cmd_o.set_status = 1'b1;
              cmd_o.status     = STS_BAD_ACTION;
            end
          end
          REQ_CLEAR: begin
            cmd_o.cnt_op = CNT_CLEAR;
          end
          REQ_READ: begin
            if (sts_i.idx_bad) begin
              cmd_o.set_status = 1'b1;
              cmd_o.status     = STS_RANGE;
            end else begin
              cmd_o.rd_en  = 1'b1;
              cmd_o.rd_sel = RD_INDEX;
            end
          end
          default: ;
        endcase
      end
      ST_SCAN: begin
        cmd_o.scan    = 1'b1;
        cmd_o.capture = sts_i.hit;
      end
      ST_HIT: begin
        case (sts_i.req)
          REQ_LOOKUP: begin
            cmd_o.wr_sel  = WR_BUMP;
            cmd_o.res_hit = 1'b1;
          end
          REQ_ADD:    cmd_o.wr_sel  = WR_ACTION;
          REQ_DELETE: cmd_o.sh_init = 1'b1;
          default: ;
        endcase
      end
      ST_MISS: begin
        case (sts_i.req)
          REQ_ADD: begin
            if (sts_i.full) begin
              cmd_o.set_status = 1'b1;
              cmd_o.status     = STS_FULL;
            end else begin
              cmd_o.wr_sel = WR_APPEND;
              cmd_o.cnt_op = CNT_INC;
            end
          end
          REQ_DELETE: begin
            cmd_o.set_status = 1'b1;
            cmd_o.status     = STS_NOT_FOUND;
          end
          default: ;
        endcase
      end
      ST_READ: begin
        cmd_o.res_entry = 1'b1;
      end
      ST_SH_RD: begin
        if (sts_i.sh_more) begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RD_SHIFT;
        end else begin
          cmd_o.cnt_op = CNT_DEC;
        end
      end
      ST_SH_WR: begin
        cmd_o.wr_sel = WR_SHIFT;
        cmd_o.sh_inc = 1'b1;
      end
      ST_DONE: begin
        cmd_o.push = !sts_i.out_busy;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ===== design/sipft_dp.sv =====
// Datapath of the source IP filter table: request registers, rule count,
// scan counters, table RAM and the output register. Depends on sipft_pkg and sipft_ram.
`default_nettype none

module sipft_dp (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic [sipft_pkg::REQ_W-1:0]       req_type_i,
  input  wire logic [sipft_pkg::IP_W-1:0]        src_ip_i,
  input  wire logic [sipft_pkg::ACT_W-1:0]       action_i,
  input  wire logic [sipft_pkg::IDX_W-1:0]       entry_index_i,
  input  wire sipft_pkg::cmd_t                   cmd_i,
  output      sipft_pkg::sts_t                   sts_o,
  output      logic                              out_valid_o,
  input  wire logic                              out_ready_i,
  output      logic [sipft_pkg::OUT_DATA_W-1:0]  out_data_o
);

  import sipft_pkg::*;

  // Request registers
  logic [REQ_W-1:0]  req_q;
  logic [IP_W-1:0]   ip_q;
  logic [ACT_W-1:0]  act_q;
  logic [IDX_W-1:0]  eidx_q;

  // Control state
  logic [CNT_W-1:0]  count_q, count_d;
  logic [CNT_W-1:0]  rd_idx_q, rd_idx_d;
  logic              pv_q;
  logic              out_valid_q, out_valid_d;

  // Working registers
  logic [IDX_W-1:0]  cmp_idx_q;
  logic [IDX_W-1:0]  hit_idx_q;
  logic [IDX_W-1:0]  sh_q;
  entry_t            ent_q;
  res_t              res_q;
  res_t              out_res_q;
  logic [CNT_W-1:0]  out_cnt_q;

  // RAM ports
  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  entry_t            ram_wdata;
  logic              ram_re;
  logic [IDX_W-1:0]  ram_raddr;
  logic [$bits(entry_t)-1:0] ram_rdata;
  entry_t            rd_ent;

  logic              issue;
  logic [CNT_W-1:0]  sh_next;

  assign rd_ent  = entry_t'(ram_rdata);
  assign issue   = cmd_i.scan && (rd_idx_q < count_q);
  assign sh_next = {1'b0, sh_q} + CNT_W'(1);

  // Status back to the controller
  always_comb begin
    sts_o          = '0;
    sts_o.req      = req_q;
    sts_o.act_bad  = (act_q > ACT_W'(1));
    sts_o.idx_bad  = ({1'b0, eidx_q} >= count_q);
    sts_o.full     = (count_q >= CNT_W'(MAX_RULES));
    sts_o.hit      = pv_q && (rd_ent.addr == ip_q);
    sts_o.miss     = !pv_q && !(rd_idx_q < count_q);
    sts_o.sh_more  = (sh_next < count_q);
    sts_o.out_busy = out_valid_q && !out_ready_i;
  end

  // Rule count update
  always_comb begin
    case (cmd_i.cnt_op)
      CNT_CLEAR: count_d = '0;
      CNT_INC:   count_d = count_q + CNT_W'(1);
      CNT_DEC:   count_d = count_q - CNT_W'(1);
      default:   count_d = count_q;
    endcase
  end

  // Scan read pointer: restart on each request, advance on each issued read
  always_comb begin
    rd_idx_d = rd_idx_q;
    if (cmd_i.accept) begin
      rd_idx_d = '0;
    end else if (issue) begin
      rd_idx_d = rd_idx_q + CNT_W'(1);
    end
  end

  // Hold a result until taken, load a new one on push
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.push) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      rd_idx_q    <= '0;
      pv_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      rd_idx_q    <= rd_idx_d;
      pv_q        <= issue;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      req_q  <= req_type_i;
      ip_q   <= src_ip_i;
      act_q  <= action_i;
      eidx_q <= entry_index_i;
      res_q  <= '0;
    end else begin
      if (cmd_i.set_status) begin
        res_q.status <= cmd_i.status;
      end
      if (cmd_i.res_hit) begin
        res_q.verdict     <= ent_q.drop;
        res_q.matched     <= 1'b1;
        res_q.match_index <= hit_idx_q;
      end
      if (cmd_i.res_entry) begin
        res_q.entry_src_ip <= rd_ent.addr;
        res_q.entry_action <= rd_ent.drop;
        res_q.entry_hits   <= rd_ent.hits;
      end
    end
    if (issue) begin
      cmp_idx_q <= rd_idx_q[IDX_W-1:0];
    end
    if (cmd_i.capture) begin
      ent_q     <= rd_ent;
      hit_idx_q <= cmp_idx_q;
    end
    if (cmd_i.sh_init) begin
      sh_q <= hit_idx_q;
    end else if (cmd_i.sh_inc) begin
      sh_q <= sh_q + IDX_W'(1);
    end
    if (cmd_i.push) begin
      out_res_q <= res_q;
      out_cnt_q <= count_q;
    end
  end

  // Table RAM read address
  always_comb begin
    case (cmd_i.rd_sel)
      RD_INDEX: ram_raddr = eidx_q;
      RD_SHIFT: ram_raddr = sh_next[IDX_W-1:0];
      default:  ram_raddr = rd_idx_q[IDX_W-1:0];
    endcase
  end

  assign ram_re = issue || cmd_i.rd_en;

  // Table RAM write: bump hits, update action, append, or move an entry down
  always_comb begin
    ram_we    = 1'b1;
    ram_waddr = hit_idx_q;
    ram_wdata = ent_q;
    case (cmd_i.wr_sel)
      WR_BUMP: begin
        ram_wdata.hits = ent_q.hits + HITS_W'(1);
      end
      WR_ACTION: begin
        ram_wdata.drop = act_q[0];
      end
      WR_APPEND: begin
        ram_waddr      = count_q[IDX_W-1:0];
        ram_wdata.addr = ip_q;
        ram_wdata.drop = act_q[0];
        ram_wdata.hits = '0;
      end
      WR_SHIFT: begin
        ram_waddr = sh_q;
        ram_wdata = rd_ent;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  sipft_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (MAX_RULES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Pack the result, first field in the lowest bits
  assign out_valid_o = out_valid_q;
  assign out_data_o  = OUT_DATA_W'({out_res_q.entry_hits,
                                    out_res_q.entry_action,
                                    out_res_q.entry_src_ip,
                                    out_cnt_q,
                                    out_res_q.match_index,
                                    out_res_q.matched,
                                    out_res_q.verdict,
                                    out_res_q.status});

`ifndef SYNTHESIS
  ap_no_append_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.cnt_op == CNT_INC |-> count_q < CNT_W'(MAX_RULES))
    else $error("append issued on a full table");

  ap_no_dec_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.cnt_op == CNT_DEC |-> count_q != '0)
    else $error("delete finished on an empty table");

  ap_push_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.push |-> (!out_valid_q || out_ready_i))
    else $error("result pushed over a pending result");

  ap_shift_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.wr_sel == WR_SHIFT |-> sh_next < count_q)
    else $error("entry moved from beyond the rule count");

  ap_cmp_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.capture |-> ({1'b0, cmp_idx_q} < count_q))
    else $error("match captured beyond the rule count");
`endif

endmodule

`default_nettype wire

// ===== design/source_ip_filter_table_top.sv =====
// Lookup, add and delete scan the table one entry per cycle through the single read port
// of the table RAM; a delete that hits then moves each later entry down one place and
// lowers the rule count by one. Clear, read and rejected requests do not scan. One request
// is worked on at a time; a result waits while the previous one is not taken, and the next
// request is taken the cycle after the result enters the output register.
// Reset empties the table (rule count zero); RAM contents are left as they are.
`default_nettype none

module source_ip_filter_table_top (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 s_axis_tvalid,
  output      logic                                 s_axis_tready,
  // src_ip[31:0], action[39:32], entry_index[45:40], zero pad
  input  wire logic [sipft_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // req_type[2:0]
  input  wire logic [sipft_pkg::REQ_W-1:0]          s_axis_tuser,
  output      logic                                 m_axis_tvalid,
  input  wire logic                                 m_axis_tready,
  // status[2:0], verdict[3], matched[4], match_index[10:5], rule_count[17:11],
  // entry_src_ip[49:18], entry_action[50], entry_hits[114:51], zero pad
  output      logic [sipft_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);

  import sipft_pkg::*;

  cmd_t cmd;
  sts_t sts;

  sipft_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid),
    .req_ready_o (s_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  sipft_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_type_i    (s_axis_tuser),
    .src_ip_i      (s_axis_tdata[IP_W-1:0]),
    .action_i      (s_axis_tdata[IP_W+ACT_W-1:IP_W]),
    .entry_index_i (s_axis_tdata[IN_FIELDS_W-1:IP_W+ACT_W]),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_data_o    (m_axis_tdata)
  );

endmodule

`default_nettype wire
